[design/dq_pkg.sv]
// ----------------------------------------------------------------------------
// dq_pkg: shared types and constants of the double-ended queue
// Operation codes, status codes, channel packing widths and cell controls.
// ----------------------------------------------------------------------------
`default_nettype none

package dq_pkg;

  localparam int DEF_DEPTH     = 16;
  localparam int DEF_WORD_BITS = 32;

  // Fixed field widths on the channels
  localparam int VALUE_W    = 32;
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 2;
  localparam int FILL_W     = 5;
  localparam int IN_DATA_W  = 32;                 // value_in
  localparam int OUT_DATA_W = 40;                 // value_out, fill_count, pad

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_REAR  = 2'd0,
    CMD_PUSH_FRONT = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_REAR   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_OVER  = 2'd1,
    ST_UNDER = 2'd2
  } status_t;

  // Operation that actually takes effect this cycle (at most one bit set)
  typedef struct packed {
    logic push_rear;
    logic push_front;
    logic pop_front;
    logic pop_rear;
  } dq_op_t;

  // Per-cell control
  typedef struct packed {
    logic shift_r;   // take the word of the left neighbour
    logic shift_l;   // take the word of the right neighbour
    logic load;      // take the incoming word
  } cell_ctrl_t;

endpackage

`default_nettype wire

[design/dq_cell.sv]
// ----------------------------------------------------------------------------
// dq_cell: one storage cell of the queue row
// Holds one word; shifts towards either neighbour or loads a new word.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_cell #(
  parameter int WORD_BITS = dq_pkg::DEF_WORD_BITS
) (
  input  wire logic                   clk,
  input  wire dq_pkg::cell_ctrl_t     ctrl,
  input  wire logic [WORD_BITS-1:0]   left_word,
  input  wire logic [WORD_BITS-1:0]   right_word,
  input  wire logic [WORD_BITS-1:0]   new_word,
  output logic      [WORD_BITS-1:0]   word
);
  import dq_pkg::*;

  logic [WORD_BITS-1:0] word_r;
  logic [WORD_BITS-1:0] word_nxt;

  always_comb begin
    if (ctrl.shift_r) begin
      word_nxt = left_word;
    end else if (ctrl.shift_l) begin
      word_nxt = right_word;
    end else if (ctrl.load) begin
      word_nxt = new_word;
    end else begin
      word_nxt = word_r;
    end
  end

  // payload only: no reset
  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

endmodule

`default_nettype wire

[design/dq_ctrl.sv]
// ----------------------------------------------------------------------------
// dq_ctrl: operation decode and fill count update
// Checks full and empty, picks the status and the next fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_ctrl #(
  parameter int DEPTH = dq_pkg::DEF_DEPTH,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  wire logic               accept,
  input  wire dq_pkg::cmd_t       cmd,
  input  wire logic [CW-1:0]      cnt,
  output dq_pkg::dq_op_t          op,
  output dq_pkg::status_t         status,
  output logic [CW-1:0]           cnt_nxt
);
  import dq_pkg::*;

  logic full;
  logic empty;

  assign full  = (cnt == CW'(DEPTH));
  assign empty = (cnt == '0);

  always_comb begin
    op      = '0;
    status  = ST_OK;
    cnt_nxt = cnt;
    unique case (cmd)
      CMD_PUSH_REAR, CMD_PUSH_FRONT: begin
        if (full) begin
          status = ST_OVER;
        end else begin
          op.push_rear  = accept && (cmd == CMD_PUSH_REAR);
          op.push_front = accept && (cmd == CMD_PUSH_FRONT);
          if (accept) begin
            cnt_nxt = cnt + CW'(1);
          end
        end
      end
      CMD_POP_FRONT, CMD_POP_REAR: begin
        if (empty) begin
          status = ST_UNDER;
        end else begin
          op.pop_front = accept && (cmd == CMD_POP_FRONT);
          op.pop_rear  = accept && (cmd == CMD_POP_REAR);
          if (accept) begin
            cnt_nxt = cnt - CW'(1);
          end
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

endmodule

`default_nettype wire

[design/double_ended_queue.sv]
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque of signed words
// A row of DEPTH cells, front word always in cell 0, rear in cell count-1.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one word per operation. in_tuser carries the command (push rear,
//           push front, pop front, pop rear), in_tdata the word to push.
//   out_* : one result word per operation. out_tdata carries the popped word
//           (zero for pushes and failed pops) and the fill count after the
//           operation; out_tuser carries the status (ok, overflow, underflow).
//   Result: registered; it appears in the cycle after the operation is taken.
//   Throughput: one operation per cycle. Each operation is finished in the
//   cycle it is taken: push front / pop front shift the whole cell row by one
//   place, push rear loads the cell at the fill count, pop rear reads cell count-1.
//   The result register is the only stage, so the rate is set by it: a new
//   operation is taken whenever the result register is empty or being drained.
//   Stall: while out_tvalid is high and out_tready low, in_tready is low and
//   the queue and the result are held.
//   Reset: fill count cleared, no result pending. Cell contents are
//   not cleared; a cell is only ever read after it was written.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue #(
  parameter int DEPTH     = dq_pkg::DEF_DEPTH,
  parameter int WORD_BITS = dq_pkg::DEF_WORD_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // input channel
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [dq_pkg::IN_DATA_W-1:0]   in_tdata,   // [31:0] value_in
  input  wire logic [dq_pkg::CMD_W-1:0]       in_tuser,   // [1:0] cmd
  // result channel
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic      [dq_pkg::OUT_DATA_W-1:0]  out_tdata,  // [31:0] value_out,
                                                          // [36:32] fill_count,
                                                          // [39:37] zero
  output logic      [dq_pkg::STATUS_W-1:0]    out_tuser   // [1:0] status
);
  import dq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  // Handshake
  logic accept;
  logic out_valid_r;
  logic out_valid_nxt;

  // Queue control state
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] cnt_nxt;
  dq_op_t        op;
  status_t       status;
  cmd_t          cmd;

  // Incoming word, truncated or extended to the storage width
  logic signed [WORD_BITS-1:0] new_word;

  // Cell row
  logic [WORD_BITS-1:0] cell_word [DEPTH];
  cell_ctrl_t           cell_ctrl [DEPTH];
  logic [WORD_BITS-1:0] rear_tap  [DEPTH];
  logic [WORD_BITS-1:0] rear_word;
  logic [CW-1:0]        rear_pos;

  // Result register
  logic signed [VALUE_W-1:0] value_r;
  logic signed [VALUE_W-1:0] value_nxt;
  status_t                   status_r;
  logic [FILL_W-1:0]         fill_r;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign cmd       = cmd_t'(in_tuser);
  assign new_word  = WORD_BITS'($signed(in_tdata[VALUE_W-1:0]));

  dq_ctrl #(
    .DEPTH (DEPTH),
    .CW    (CW)
  ) u_ctrl (
    .accept  (accept),
    .cmd     (cmd),
    .cnt     (cnt_r),
    .op      (op),
    .status  (status),
    .cnt_nxt (cnt_nxt)
  );

  // Rear sits at cell count-1; push rear fills cell count
  assign rear_pos = cnt_r - CW'(1);

  generate
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [WORD_BITS-1:0] left_w;
      logic [WORD_BITS-1:0] right_w;

      if (i == 0) begin : g_first
        assign left_w = new_word;
      end else begin : g_mid_l
        assign left_w = cell_word[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
        assign right_w = '0;
      end else begin : g_mid_r
        assign right_w = cell_word[i+1];
      end

      // Shift the row right on push front, left on pop front
      assign cell_ctrl[i].shift_r = op.push_front;
      assign cell_ctrl[i].shift_l = op.pop_front;
      assign cell_ctrl[i].load    = op.push_rear && (cnt_r == CW'(i));

      // Only the rear cell drives its word onto the tap
      assign rear_tap[i] = (rear_pos == CW'(i)) ? cell_word[i] : '0;

      dq_cell #(
        .WORD_BITS (WORD_BITS)
      ) u_cell (
        .clk        (clk),
        .ctrl       (cell_ctrl[i]),
        .left_word  (left_w),
        .right_word (right_w),
        .new_word   (new_word),
        .word       (cell_word[i])
      );
    end
  endgenerate

  // Merge the taps; at most one is non-zero
  always_comb begin
    rear_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rear_word = rear_word | rear_tap[i];
    end
  end

  // Popped word, sign-extended from the storage width
  always_comb begin
    if (op.pop_front) begin
      value_nxt = VALUE_W'($signed(cell_word[0]));
    end else if (op.pop_rear) begin
      value_nxt = VALUE_W'($signed(rear_word));
    end else begin
      value_nxt = '0;
    end
  end

  // Hold the result until taken; load a new one on each accepted word
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      value_r  <= value_nxt;
      status_r <= status;
      fill_r   <= FILL_W'(cnt_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - VALUE_W - FILL_W)'(0), fill_r, value_r};
  assign out_tuser  = status_r;

  // Fill count never exceeds the row length
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("fill count beyond depth");

  // A stalled result freezes the queue
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> $stable(cnt_r))
    else $error("queue moved while result stalled");

  // A front pop returns the word that sat in cell 0
  a_pop_front: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (cmd == CMD_POP_FRONT) && (cnt_r != '0)
    |=> value_r == $past(VALUE_W'($signed(cell_word[0]))))
    else $error("front pop returned wrong word");

  // Pop on empty reports underflow and leaves the count at zero
  a_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    accept && ((cmd == CMD_POP_FRONT) || (cmd == CMD_POP_REAR)) && (cnt_r == '0)
    |=> (status_r == ST_UNDER) && (cnt_r == '0) && (value_r == '0))
    else $error("empty pop not flagged");

  // Push on full reports overflow and keeps the queue full
  a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    accept && ((cmd == CMD_PUSH_REAR) || (cmd == CMD_PUSH_FRONT))
    && (cnt_r == CW'(DEPTH))
    |=> (status_r == ST_OVER) && (cnt_r == CW'(DEPTH)))
    else $error("full push not flagged");

endmodule

`default_nettype wire
